>>> design/shcf_pkg.sv
// Shared constants, types and state codes of the strip hit cluster finder.
package shcf_pkg;

	localparam int MAX_RUN     = 32;
	localparam int MAX_RESULTS = 16;
	localparam int RUN_AW      = $clog2(MAX_RUN);
	localparam int RUN_CW      = $clog2(MAX_RUN + 1);
	localparam int RES_CW      = $clog2(MAX_RESULTS + 1);

	localparam int STRIP_W  = 12;
	localparam int CHARGE_W = 17;
	localparam int POS_W    = 20;
	localparam int HITS_W   = 6;
	localparam int THR_W    = 17;
	localparam int CENT_W   = 20;
	localparam int OTOT_W   = 22;

	localparam int PROD_W = POS_W + CHARGE_W;
	localparam int TOT_W  = CHARGE_W + RUN_AW;
	localparam int WS_W   = POS_W + CHARGE_W + RUN_AW;
	localparam int CMP_W  = (RUN_CW > HITS_W) ? RUN_CW : HITS_W;

	localparam int CFG_AW = 2;
	localparam int CFG_DW = 17;
	localparam int IN_DW  = 56;
	localparam int OUT_DW = 72;

	localparam logic [CFG_AW-1:0] REG_MIN_HITS  = 2'd0;
	localparam logic [CFG_AW-1:0] REG_MAX_HITS  = 2'd1;
	localparam logic [CFG_AW-1:0] REG_SPLIT_THR = 2'd2;

	localparam logic [HITS_W-1:0] MIN_HITS_RST = 6'd1;
	localparam logic [HITS_W-1:0] MAX_HITS_RST = 6'd20;
	localparam logic [THR_W-1:0]  SPLIT_THR_RST = 17'd28;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ADD, ST_CL_START, ST_SC_INIT, ST_SC_FIRST, ST_SC_RUN, ST_HALVE,
		ST_PART, ST_ACC, ST_DIV, ST_EMIT, ST_CL_END, ST_FINISH
	} state_t;

	typedef struct packed {
		logic                eoe;
		logic                lor;
		logic                cl;
		logic [HITS_W-1:0]   count;
		logic [CHARGE_W-1:0] peak;
		logic [OTOT_W-1:0]   total;
		logic [CENT_W-1:0]   centroid;
	} res_t;

endpackage

>>> design/shcf_div.sv
// Bit-serial signed by unsigned divider, quotient truncated toward zero.
module shcf_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [shcf_pkg::WS_W-1:0]  num,
	input  logic [shcf_pkg::TOT_W-1:0]        den,
	output logic                              done,
	output logic [shcf_pkg::CENT_W-1:0]       quot
);
	localparam int NUM_W = shcf_pkg::WS_W;
	localparam int DEN_W = shcf_pkg::TOT_W;
	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q, done_q, neg_q, zero_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] q_q;
	logic [DEN_W-1:0] rem_q, den_q;
	logic [DEN_W:0]   shifted;
	logic             fits;

	assign shifted = {rem_q, q_q[NUM_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(NUM_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= num[NUM_W-1];
			zero_q <= (den == '0);
			q_q    <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
			q_q   <= {q_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = zero_q ? '0 : (neg_q ? -q_q[shcf_pkg::CENT_W-1:0] : q_q[shcf_pkg::CENT_W-1:0]);

endmodule

>>> design/strip_hit_cluster_finder_top.sv
// Top level of the strip hit cluster finder.
// A hit that closes no run passes through accept, buffer write and result
// flush. Closing a run costs a scan through the charge buffer, then for each
// kept part an accumulation over the buffer read port and a division in the
// bit-serial centroid divider, and an emit step per cluster; a split adds a
// step to halve the valley strip and a rescan of the remainder. The single
// read port of the run buffer and the serial divider set the pace. Results of
// one hit leave in order; the last carries tlast (last_of_run) and, for a hit
// marked last, tuser[1] (end_of_event). A last hit that yields no cluster gives
// one empty marker with cluster_valid low and all data zero.
module strip_hit_cluster_finder_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [shcf_pkg::CFG_AW-1:0]     cfg_idx,
	input  logic [shcf_pkg::CFG_DW-1:0]     cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [shcf_pkg::IN_DW-1:0]      s_tdata,  // strip[11:0], charge[28:12], position[48:29]
	input  logic                            s_tlast,  // last_hit
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [shcf_pkg::OUT_DW-1:0]     m_tdata,  // centroid, total, peak, hit_count
	output logic                            m_tlast,  // last_of_run
	output logic [1:0]                      m_tuser   // cluster_valid, end_of_event
);
	localparam int CW  = shcf_pkg::CHARGE_W;
	localparam int AW  = shcf_pkg::RUN_AW;
	localparam int NW  = shcf_pkg::RUN_CW;

	shcf_pkg::state_t state_q, state_d;

	// configuration
	logic [shcf_pkg::HITS_W-1:0] min_hits_q, max_hits_q;
	logic [shcf_pkg::THR_W-1:0]  thr_q;

	// run bookkeeping
	logic [NW-1:0]                    run_len_q;
	logic                             ovf_q, have_prev_q;
	logic [shcf_pkg::STRIP_W-1:0]     prev_q;

	// latched hit
	logic [shcf_pkg::STRIP_W-1:0]     strip_q;
	logic [CW-1:0]                    charge_q;
	logic signed [shcf_pkg::POS_W-1:0] pos_q;
	logic                             last_q, ret_add_q;

	// run buffer
	logic [CW-1:0]                    charge_mem [shcf_pkg::MAX_RUN];
	logic signed [shcf_pkg::POS_W-1:0] pos_mem  [shcf_pkg::MAX_RUN];
	logic [CW-1:0]                    rd_charge;
	logic signed [shcf_pkg::POS_W-1:0] rd_pos;
	logic [AW-1:0]                    raddr;
	logic                             c_we, p_we;
	logic [AW-1:0]                    c_wa;
	logic [CW-1:0]                    c_wd;

	// scan
	logic [NW-1:0] start_q, end_q, j_q, mn_q, first_q, last_idx_q, k_q;
	logic [CW-1:0] a_q, mnval_q;
	logic          down_q, split_q;
	logic [NW-1:0] mn_n;
	logic [CW-1:0] mnval_n;
	logic          down_n, found, j_end;

	// accumulation
	logic                               iss_s1, prodv_s2, issuing, acc_done;
	logic signed [shcf_pkg::PROD_W:0]   prod_full;
	logic signed [shcf_pkg::PROD_W-1:0] prod_s2;
	logic [shcf_pkg::TOT_W-1:0]         tot_q;
	logic [CW-1:0]                      peak_q;
	logic signed [shcf_pkg::WS_W-1:0]   wsum_q;

	// divider
	logic                        div_start, div_done;
	logic [shcf_pkg::CENT_W-1:0] div_quot;

	// results
	shcf_pkg::res_t                pend_q, out_q, fin_res;
	logic                          pend_v_q, out_v_q, out_free, out_load;
	logic [shcf_pkg::RES_CW-1:0]   res_cnt_q;
	logic [NW-1:0]                 count;
	logic                          keep, gap;

	assign out_free = !out_v_q || m_tready;
	assign out_load = (out_free && pend_v_q && (state_q == shcf_pkg::ST_EMIT))
	               || (out_free && (pend_v_q || last_q) && (state_q == shcf_pkg::ST_FINISH));
	assign count    = NW'(last_idx_q - first_q + 1'b1);
	assign keep     = (shcf_pkg::CMP_W'(count) >= shcf_pkg::CMP_W'(min_hits_q))
	               && (shcf_pkg::CMP_W'(count) <= shcf_pkg::CMP_W'(max_hits_q))
	               && (res_cnt_q < shcf_pkg::RES_CW'(shcf_pkg::MAX_RESULTS));
	assign gap      = have_prev_q
	               && ({1'b0, s_tdata[11:0]} != ({1'b0, prev_q} + 1'b1));
	assign issuing  = k_q <= last_idx_q;
	assign acc_done = !issuing && !iss_s1 && !prodv_s2;
	assign j_end    = (j_q == NW'(end_q - 1'b1));

	// final result of a hit: the held cluster, or an empty marker at event end
	always_comb begin
		fin_res     = pend_v_q ? pend_q : '0;
		fin_res.lor = 1'b1;
		fin_res.eoe = last_q;
	end

	// valley search on the neighbor pair (a = c[j-1], b = c[j])
	always_comb begin
		mn_n    = mn_q;
		mnval_n = mnval_q;
		down_n  = down_q;
		found   = 1'b0;
		if (down_q) begin
			if (a_q < mnval_q) begin
				mn_n    = NW'(j_q - 1'b1);
				mnval_n = a_q;
			end
			if ({1'b0, rd_charge} > ({1'b0, a_q} + (CW+1)'(thr_q)))
				found = 1'b1;
		end else if ({1'b0, a_q} > ({1'b0, rd_charge} + (CW+1)'(thr_q))) begin
			down_n  = 1'b1;
			mn_n    = j_q;
			mnval_n = rd_charge;
		end
	end

	// next state and strobes
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		raddr     = start_q[AW-1:0];
		c_we      = 1'b0;
		p_we      = 1'b0;
		c_wa      = run_len_q[AW-1:0];
		c_wd      = charge_q;
		div_start = 1'b0;
		unique case (state_q)
			shcf_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = gap ? shcf_pkg::ST_CL_START : shcf_pkg::ST_ADD;
			end
			shcf_pkg::ST_ADD: begin
				if (run_len_q < NW'(shcf_pkg::MAX_RUN)) begin
					c_we = 1'b1;
					p_we = 1'b1;
				end
				state_d = last_q ? shcf_pkg::ST_CL_START : shcf_pkg::ST_FINISH;
			end
			shcf_pkg::ST_CL_START: begin
				state_d = (ovf_q || run_len_q == '0) ? shcf_pkg::ST_CL_END
				                                     : shcf_pkg::ST_SC_INIT;
			end
			shcf_pkg::ST_SC_INIT: begin
				raddr   = start_q[AW-1:0];
				state_d = (NW'(end_q - start_q) >= NW'(3)) ? shcf_pkg::ST_SC_FIRST
				                                           : shcf_pkg::ST_PART;
			end
			shcf_pkg::ST_SC_FIRST: begin
				raddr   = j_q[AW-1:0];
				state_d = shcf_pkg::ST_SC_RUN;
			end
			shcf_pkg::ST_SC_RUN: begin
				raddr = AW'(j_q + 1'b1);
				if (found)
					state_d = shcf_pkg::ST_HALVE;
				else if (j_end)
					state_d = shcf_pkg::ST_PART;
			end
			shcf_pkg::ST_HALVE: begin
				c_we    = 1'b1;
				c_wa    = mn_q[AW-1:0];
				c_wd    = mnval_q >> 1;
				state_d = shcf_pkg::ST_PART;
			end
			shcf_pkg::ST_PART: begin
				if (keep)
					state_d = shcf_pkg::ST_ACC;
				else
					state_d = split_q ? shcf_pkg::ST_SC_INIT : shcf_pkg::ST_CL_END;
			end
			shcf_pkg::ST_ACC: begin
				raddr = k_q[AW-1:0];
				if (acc_done) begin
					div_start = 1'b1;
					state_d   = shcf_pkg::ST_DIV;
				end
			end
			shcf_pkg::ST_DIV: begin
				if (div_done)
					state_d = shcf_pkg::ST_EMIT;
			end
			shcf_pkg::ST_EMIT: begin
				if (!pend_v_q || out_free)
					state_d = split_q ? shcf_pkg::ST_SC_INIT : shcf_pkg::ST_CL_END;
			end
			shcf_pkg::ST_CL_END: begin
				state_d = ret_add_q ? shcf_pkg::ST_ADD : shcf_pkg::ST_FINISH;
			end
			shcf_pkg::ST_FINISH: begin
				if (!(pend_v_q || last_q) || out_free)
					state_d = shcf_pkg::ST_IDLE;
			end
			default: state_d = shcf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= shcf_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// configuration registers; writes beyond the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_hits_q <= shcf_pkg::MIN_HITS_RST;
			max_hits_q <= shcf_pkg::MAX_HITS_RST;
			thr_q      <= shcf_pkg::SPLIT_THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				shcf_pkg::REG_MIN_HITS:  min_hits_q <= cfg_data[shcf_pkg::HITS_W-1:0];
				shcf_pkg::REG_MAX_HITS:  max_hits_q <= cfg_data[shcf_pkg::HITS_W-1:0];
				shcf_pkg::REG_SPLIT_THR: thr_q      <= cfg_data[shcf_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// run buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (c_we)
			charge_mem[c_wa] <= c_wd;
		if (p_we)
			pos_mem[run_len_q[AW-1:0]] <= pos_q;
		rd_charge <= charge_mem[raddr];
		rd_pos    <= pos_mem[raddr];
	end

	// control state: run tracking, result bookkeeping, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_len_q   <= '0;
			ovf_q       <= 1'b0;
			have_prev_q <= 1'b0;
			prev_q      <= '0;
			pend_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
			res_cnt_q   <= '0;
			iss_s1      <= 1'b0;
			prodv_s2    <= 1'b0;
		end else begin
			if (out_load)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;
			iss_s1   <= (state_q == shcf_pkg::ST_ACC) && issuing;
			prodv_s2 <= (state_q == shcf_pkg::ST_ACC) && iss_s1;
			unique case (state_q)
				shcf_pkg::ST_IDLE: begin
					if (s_tvalid)
						res_cnt_q <= '0;
				end
				shcf_pkg::ST_ADD: begin
					// hold hits beyond the buffer out; the run then yields nothing
					if (run_len_q < NW'(shcf_pkg::MAX_RUN))
						run_len_q <= run_len_q + 1'b1;
					else
						ovf_q <= 1'b1;
					prev_q      <= strip_q;
					have_prev_q <= 1'b1;
				end
				shcf_pkg::ST_EMIT: begin
					// a newer cluster pushes the held one out
					if (!pend_v_q || out_free) begin
						pend_v_q  <= 1'b1;
						res_cnt_q <= res_cnt_q + 1'b1;
					end
				end
				shcf_pkg::ST_CL_END: begin
					run_len_q <= '0;
					ovf_q     <= 1'b0;
				end
				shcf_pkg::ST_FINISH: begin
					// flag and transfer the final result of this hit
					if ((pend_v_q || last_q) && out_free)
						pend_v_q <= 1'b0;
					if (last_q) begin
						have_prev_q <= 1'b0;
						prev_q      <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			shcf_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					strip_q   <= s_tdata[11:0];
					charge_q  <= s_tdata[28:12];
					pos_q     <= s_tdata[48:29];
					last_q    <= s_tlast;
					ret_add_q <= gap;
				end
			end
			shcf_pkg::ST_ADD: begin
				ret_add_q <= 1'b0;
			end
			shcf_pkg::ST_CL_START: begin
				start_q <= '0;
				end_q   <= run_len_q;
			end
			shcf_pkg::ST_SC_INIT: begin
				j_q        <= NW'(start_q + 1'b1);
				down_q     <= 1'b0;
				split_q    <= 1'b0;
				first_q    <= start_q;
				last_idx_q <= NW'(end_q - 1'b1);
			end
			shcf_pkg::ST_SC_FIRST: begin
				a_q <= rd_charge;
			end
			shcf_pkg::ST_SC_RUN: begin
				a_q     <= rd_charge;
				j_q     <= NW'(j_q + 1'b1);
				down_q  <= down_n;
				mn_q    <= mn_n;
				mnval_q <= mnval_n;
				if (found) begin
					split_q    <= 1'b1;
					last_idx_q <= mn_n;
				end
			end
			shcf_pkg::ST_PART: begin
				k_q    <= first_q;
				tot_q  <= '0;
				peak_q <= '0;
				wsum_q <= '0;
				if (!keep && split_q)
					start_q <= mn_q;
			end
			shcf_pkg::ST_ACC: begin
				if (issuing)
					k_q <= NW'(k_q + 1'b1);
				if (iss_s1) begin
					tot_q   <= tot_q + shcf_pkg::TOT_W'(rd_charge);
					if (rd_charge > peak_q)
						peak_q <= rd_charge;
					prod_s2 <= prod_full[shcf_pkg::PROD_W-1:0];
				end
				if (prodv_s2)
					wsum_q <= wsum_q + shcf_pkg::WS_W'(prod_s2);
			end
			shcf_pkg::ST_EMIT: begin
				if (!pend_v_q || out_free) begin
					if (pend_v_q)
						out_q <= pend_q;
					pend_q <= '{eoe: 1'b0, lor: 1'b0, cl: 1'b1,
					            count: shcf_pkg::HITS_W'(count), peak: peak_q,
					            total: shcf_pkg::OTOT_W'(tot_q), centroid: div_quot};
					if (split_q)
						start_q <= mn_q;
				end
			end
			shcf_pkg::ST_FINISH: begin
				if (out_free && (pend_v_q || last_q))
					out_q <= fin_res;
			end
			default: ;
		endcase
	end

	assign prod_full = rd_pos * $signed({1'b0, rd_charge});

	shcf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (wsum_q),
		.den    (tot_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign m_tvalid = out_v_q;
	assign m_tdata  = {7'd0, out_q.count, out_q.peak, out_q.total, out_q.centroid};
	assign m_tlast  = out_q.lor;
	assign m_tuser  = {out_q.eoe, out_q.cl};

endmodule

>>> design/shcf_chk.sv
// Port-level checker of the strip hit cluster finder, bound to the top level.
module shcf_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [shcf_pkg::OUT_DW-1:0] m_tdata,
	input logic                        m_tlast,
	input logic [1:0]                  m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second hit taken while one is in work");

	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && m_tuser[1] && m_tdata == '0)
		else $error("malformed end marker");

	a_eoe_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("event end without run end");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[64:59] != '0)
		else $error("cluster with no hits");

endmodule

bind strip_hit_cluster_finder_top shcf_chk u_shcf_chk (.*);
